>>> design/pmq_pkg.sv
`default_nettype none

package pmq_pkg;

  localparam int HANDLE_W = 16;
  localparam int PRI_W    = 8;
  localparam int STATUS_W = 2;

  typedef enum logic {
    OP_SEND    = 1'b0,
    OP_RECEIVE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRI_W-1:0]    pri;
  } entry_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic   push;
    logic   pop;
    logic   mode;
    entry_t item;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> design/priority_mailbox_queue.sv
// priority_mailbox_queue: mailbox of 16-bit message handles with optional
// stable priority ordering.
// Input: pulse start with in_op, in_message_handle, in_priority_req; the
// transaction is taken at a rising edge with start high and busy low. busy
// stays low, so a new send or receive may be issued every cycle.
// Output: one result per transaction, shown on out_status,
// out_received_handle and out_has_message for exactly one cycle with
// out_valid high, the cycle after the transaction is taken (one transaction
// per cycle). The receiver cannot stall the result.
// Storage is a row of DEPTH cells, head at cell 0. A send inserts in place:
// in priority mode each cell compares its priority with the new one, and a
// ripple flag through the row picks the insert point; later cells take their
// left neighbor. A receive shifts every cell toward the head.
// cfg_wr_en / cfg_wr_data set priority mode (1) or fifo mode (0); write only
// while no transaction is outstanding.
// Reset (rst_n low, synchronous) empties the queue, selects fifo mode and
// drops out_valid. No clearing pass is needed.
`default_nettype none

module priority_mailbox_queue #(
  parameter int DEPTH = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire                          in_op,
  input  wire  [pmq_pkg::HANDLE_W-1:0] in_message_handle,
  input  wire  [pmq_pkg::PRI_W-1:0]    in_priority_req,
  output logic                         out_valid,
  output logic [pmq_pkg::STATUS_W-1:0] out_status,
  output logic [pmq_pkg::HANDLE_W-1:0] out_received_handle,
  output logic                         out_has_message,
  input  wire                          cfg_wr_en,
  input  wire                          cfg_wr_data
);

  import pmq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic                mode_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic                valid_r;
  status_t             status_r;
  status_t             status_nxt;
  logic [HANDLE_W-1:0] handle_r;
  logic [HANDLE_W-1:0] handle_nxt;
  logic                has_r;

  logic       accept;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;

  entry_t q     [DEPTH];
  logic   chain [DEPTH+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);

  assign ctrl.push        = accept && (op_t'(in_op) == OP_SEND) && !full;
  assign ctrl.pop         = accept && (op_t'(in_op) == OP_RECEIVE) && !empty;
  assign ctrl.mode        = mode_r;
  assign ctrl.item.handle = in_message_handle;
  assign ctrl.item.pri    = in_priority_req;

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    if (i == 0) begin : g_head
      assign left_e = ctrl.item;
    end else begin : g_mid
      assign left_e = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_e = q[i];
    end else begin : g_body
      assign right_e = q[i+1];
    end
    pmq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (CW'(i) < count_r),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .left      (left_e),
      .right     (right_e),
      .q         (q[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    handle_nxt = '0;
    if (op_t'(in_op) == OP_SEND) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        count_nxt  = count_r - CW'(1);
        handle_nxt = q[0].handle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      handle_r <= handle_nxt;
      has_r    <= (count_nxt != '0);
    end
  end

  assign out_valid           = valid_r;
  assign out_status          = status_r;
  assign out_received_handle = handle_r;
  assign out_has_message     = has_r;

endmodule

`default_nettype wire

>>> design/pmq_cell.sv
`default_nettype none

module pmq_cell (
  input  wire                 clk,
  input  pmq_pkg::cell_ctrl_t ctrl,
  input  wire                 occupied,
  input  wire                 chain_in,
  output logic                chain_out,
  input  pmq_pkg::entry_t     left,
  input  pmq_pkg::entry_t     right,
  output pmq_pkg::entry_t     q
);

  import pmq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   mark;

  // a free cell always accepts; an occupied one only in priority mode when it sorts after the new item
  assign mark      = occupied ? (ctrl.mode && (entry_r.pri > ctrl.item.pri)) : 1'b1;
  assign chain_out = chain_in | mark;
  assign q         = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.push) begin
      if (chain_in) begin
        entry_nxt = left;
      end else if (mark) begin
        entry_nxt = ctrl.item;
      end
    end else if (ctrl.pop) begin
      entry_nxt = right;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_priority_mailbox_queue.sv
`default_nettype none

module tb_priority_mailbox_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import pmq_pkg::*;

  localparam int MB_DEPTH    = 16;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic                has_msg;
  } reply_t;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic                mode_val;
    op_t                 op;
    logic [HANDLE_W-1:0] handle;
    logic [PRI_W-1:0]    pri;
    logic [7:0]          reps;
    logic                pinned;
    reply_t              want;
  } plan_row_t;

  localparam reply_t NO_REPLY = '{ST_OK, 16'h0, 1'b0};

  logic                clk                 = 1'b0;
  logic                rst_n               = 1'b0;
  logic                start               = 1'b0;
  logic                in_op               = 1'b0;
  logic [HANDLE_W-1:0] in_message_handle   = '0;
  logic [PRI_W-1:0]    in_priority_req     = '0;
  logic                cfg_wr_en           = 1'b0;
  logic                cfg_wr_data         = 1'b0;
  wire                 busy;
  wire                 out_valid;
  wire  [STATUS_W-1:0] out_status;
  wire  [HANDLE_W-1:0] out_received_handle;
  wire                 out_has_message;

  logic   pin_valid = 1'b0;
  reply_t pin_reply = NO_REPLY;

  entry_t queued_msgs[$];
  logic   mode_shadow = 1'b0;
  reply_t replies_due[$];

  int errors     = 0;
  int cycles     = 0;
  int n_taken    = 0;
  int n_checked  = 0;
  int n_full     = 0;
  int n_empty    = 0;
  int n_popped   = 0;
  int n_mode_wr  = 0;

  plan_row_t plan [0:19] = '{
    '{ROW_ITEM, 1'b0, OP_RECEIVE, 16'h0000, 8'h00, 8'd1,  1'b1, '{ST_EMPTY, 16'h0000, 1'b0}},
    '{ROW_ITEM, 1'b0, OP_SEND,    16'hFFFF, 8'h00, 8'd1,  1'b1, '{ST_OK,    16'h0000, 1'b1}},
    '{ROW_ITEM, 1'b0, OP_SEND,    16'h0000, 8'hFF, 8'd1,  1'b1, '{ST_OK,    16'h0000, 1'b1}},
    '{ROW_ITEM, 1'b0, OP_RECEIVE, 16'h0000, 8'h00, 8'd1,  1'b1, '{ST_OK,    16'hFFFF, 1'b1}},
    '{ROW_ITEM, 1'b0, OP_RECEIVE, 16'h0000, 8'h00, 8'd1,  1'b1, '{ST_OK,    16'h0000, 1'b0}},
    '{ROW_CFG,  1'b1, OP_SEND,    16'h0000, 8'h00, 8'd0,  1'b0, NO_REPLY},
    '{ROW_ITEM, 1'b0, OP_SEND,    16'h1234, 8'h07, 8'd1,  1'b0, NO_REPLY},
    '{ROW_ITEM, 1'b0, OP_SEND,    16'h2345, 8'h07, 8'd1,  1'b0, NO_REPLY},
    '{ROW_ITEM, 1'b0, OP_SEND,    16'h3456, 8'h03, 8'd1,  1'b0, NO_REPLY},
    '{ROW_ITEM, 1'b0, OP_SEND,    16'h4567, 8'hFF, 8'd1,  1'b0, NO_REPLY},
    '{ROW_ITEM, 1'b0, OP_SEND,    16'h5678, 8'h00, 8'd12, 1'b0, NO_REPLY},
    '{ROW_ITEM, 1'b0, OP_SEND,    16'hAAAA, 8'h00, 8'd1,  1'b1, '{ST_FULL,  16'h0000, 1'b1}},
    '{ROW_ITEM, 1'b0, OP_RECEIVE, 16'h0000, 8'h00, 8'd2,  1'b0, NO_REPLY},
    '{ROW_CFG,  1'b0, OP_SEND,    16'h0000, 8'h00, 8'd0,  1'b0, NO_REPLY},
    '{ROW_ITEM, 1'b0, OP_SEND,    16'hBEEF, 8'h00, 8'd1,  1'b0, NO_REPLY},
    '{ROW_CFG,  1'b1, OP_SEND,    16'h0000, 8'h00, 8'd0,  1'b0, NO_REPLY},
    '{ROW_ITEM, 1'b0, OP_SEND,    16'hC0DE, 8'h05, 8'd1,  1'b0, NO_REPLY},
    '{ROW_ITEM, 1'b0, OP_RECEIVE, 16'h0000, 8'h00, 8'd16, 1'b0, NO_REPLY},
    '{ROW_ITEM, 1'b0, OP_RECEIVE, 16'h0000, 8'h00, 8'd1,  1'b1, '{ST_EMPTY, 16'h0000, 1'b0}},
    '{ROW_CFG,  1'b0, OP_SEND,    16'h0000, 8'h00, 8'd0,  1'b0, NO_REPLY}
  };

  priority_mailbox_queue DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_message_handle   (in_message_handle),
    .in_priority_req     (in_priority_req),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_received_handle (out_received_handle),
    .out_has_message     (out_has_message),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_priority_mailbox_queue: errors");
      $finish;
    end
  end

  function automatic reply_t mailbox_apply(op_t op, logic [HANDLE_W-1:0] h,
                                           logic [PRI_W-1:0] p);
    reply_t r;
    entry_t e;
    int     pos;
    r = NO_REPLY;
    if (op == OP_SEND) begin
      if (queued_msgs.size() >= MB_DEPTH) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        e.handle = h;
        e.pri    = p;
        pos      = queued_msgs.size();
        if (mode_shadow) begin
          for (int i = queued_msgs.size() - 1; i >= 0; i--) begin
            if (queued_msgs[i].pri > p) pos = i;
          end
        end
        queued_msgs.insert(pos, e);
      end
    end else begin
      if (queued_msgs.size() == 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        e        = queued_msgs.pop_front();
        r.handle = e.handle;
        n_popped++;
      end
    end
    r.has_msg = (queued_msgs.size() != 0);
    return r;
  endfunction

  // samples pre-edge values: results first, then config, then the new transaction
  always @(posedge clk) begin : watch
    reply_t want;
    reply_t guess;
    if (rst_n) begin
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          $error("result with no transaction waiting: status %0d handle %h",
                 out_status, out_received_handle);
          errors++;
        end else begin
          want = replies_due.pop_front();
          n_checked++;
          if (out_status !== want.status) begin
            $error("out_status expected %0d got %0d", want.status, out_status);
            errors++;
          end
          if (out_received_handle !== want.handle) begin
            $error("out_received_handle expected %h got %h", want.handle,
                   out_received_handle);
            errors++;
          end
          if (out_has_message !== want.has_msg) begin
            $error("out_has_message expected %0d got %0d", want.has_msg,
                   out_has_message);
            errors++;
          end
        end
      end
      if (cfg_wr_en) mode_shadow = cfg_wr_data;
      if (start && !busy) begin
        guess = mailbox_apply(op_t'(in_op), in_message_handle, in_priority_req);
        replies_due.push_back(pin_valid ? pin_reply : guess);
        n_taken++;
      end
    end
  end

  task automatic drive_item(op_t op, logic [HANDLE_W-1:0] h, logic [PRI_W-1:0] p,
                            logic pinned, reply_t want);
    start             <= 1'b1;
    in_op             <= op;
    in_message_handle <= h;
    in_priority_req   <= p;
    pin_valid         <= pinned;
    pin_reply         <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_for(int n);
    start     <= 1'b0;
    pin_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_replies();
    start     <= 1'b0;
    pin_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    drain_replies();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    n_mode_wr++;
  endtask

  task automatic run_burst(int n_items, int send_pct, int pri_max, int gap_pct);
    op_t op;
    for (int k = 0; k < n_items; k++) begin
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        idle_for($urandom_range(1, 19));
      op = ($urandom_range(0, 99) < send_pct) ? OP_SEND : OP_RECEIVE;
      drive_item(op, HANDLE_W'($urandom), PRI_W'($urandom_range(0, pri_max)), 1'b0,
                 NO_REPLY);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        write_mode(plan[r].mode_val);
      end else begin
        for (int k = 0; k < plan[r].reps; k++)
          drive_item(plan[r].op, HANDLE_W'(plan[r].handle + k), PRI_W'(plan[r].pri + k),
                     plan[r].pinned, plan[r].want);
      end
    end

    write_mode(1'b1);
    run_burst(150, 75, 3, 20);
    run_burst(120, 25, 255, 10);
    write_mode(1'b0);
    run_burst(150, 60, 255, 25);
    run_burst(100, 30, 255, 0);
    write_mode(1'b1);
    run_burst(130, 55, 15, 15);
    write_mode(1'($urandom_range(0, 1)));
    run_burst(200, 50, 255, 0);

    start     <= 1'b0;
    pin_valid <= 1'b0;
    for (int w = 0; w < 200 && replies_due.size() != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (replies_due.size() != 0) begin
      $error("%0d results never arrived", replies_due.size());
      errors++;
    end

    $display("run covered %0d transactions in %0d mode writes, %0d results checked",
             n_taken, n_mode_wr, n_checked);
    $display("  %0d handles popped, %0d empty receives, %0d full rejects",
             n_popped, n_empty, n_full);
    if (errors == 0) begin
      $display("tb_priority_mailbox_queue: clean");
    end else begin
      $display("tb_priority_mailbox_queue: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> priority_mailbox_queue.f
design/pmq_pkg.sv
design/pmq_cell.sv
design/priority_mailbox_queue.sv
tb/sv/tb_priority_mailbox_queue.sv
